[rtl/pqld_pkg.sv]
// shared types and constants for the phantom queue link delay block
`timescale 1ns / 1ps
package pqld_pkg;

  localparam int TimeW   = 48;
  localparam int BytesW  = 16;
  localparam int DelayW  = 40;
  localparam int QueueW  = 24;
  localparam int CfgW    = 32;
  localparam int CfgIdxW = 3;

  localparam logic [TimeW-1:0]  TimeMax   = {TimeW{1'b1}};
  localparam logic [DelayW-1:0] DelayMax  = {DelayW{1'b1}};
  localparam logic [QueueW-1:0] QueueMax  = {QueueW{1'b1}};
  localparam logic [31:0]       ByteTimeReset = 32'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PQ_ENABLE,
    REG_AVOID_REORDER,
    REG_BYTE_TIME,
    REG_LINK_DELAY,
    REG_DRAIN_RATE,
    REG_MARK_THRESHOLD
  } cfg_reg_t;

  typedef struct packed {
    logic              pq_enable;
    logic              avoid_reorder;
    logic [31:0]       byte_time;
    logic [31:0]       link_delay;
    logic [31:0]       drain_rate;
    logic [QueueW-1:0] mark_threshold;
  } pqld_cfg_t;

  typedef struct packed {
    logic accept;
    logic advance;
    logic s0_valid;
    logic s1_valid;
  } pqld_ctrl_t;

endpackage

[rtl/pqld_in_if.sv]
// input channel: packet arrival words
`timescale 1ns / 1ps
interface pqld_in_if;
  import pqld_pkg::*;
  logic              valid;
  logic              ready;
  logic [TimeW-1:0]  arrival_time;
  logic [BytesW-1:0] packet_bytes;
  modport source (output valid, output arrival_time, output packet_bytes, input ready);
  modport sink   (input valid, input arrival_time, input packet_bytes, output ready);
endinterface

[rtl/pqld_out_if.sv]
// result channel: delays, marking and phantom occupancy
`timescale 1ns / 1ps
interface pqld_out_if;
  import pqld_pkg::*;
  logic              valid;
  logic              ready;
  logic [DelayW-1:0] deliver_delay;
  logic [DelayW-1:0] release_delay;
  logic              mark_ce;
  logic [QueueW-1:0] queue_bytes;
  modport source (output valid, output deliver_delay, output release_delay,
                  output mark_ce, output queue_bytes, input ready);
  modport sink   (input valid, input deliver_delay, input release_delay,
                  input mark_ce, input queue_bytes, output ready);
endinterface

[rtl/phantom_queue_link_delay.sv]
// phantom queue link delay top level: config registers, pipeline and delay logic
// a result is registered through the capture, multiply and update stages before it is valid
// throughput: one word per cycle unless out_res stalls; capture, multiply and update stages advance together
// the whole pipeline holds while a finished result waits on out_res.ready
// synchronous active-low reset clears valids, config to defaults and all queue state
// no clearing pass after reset
`timescale 1ns / 1ps
module phantom_queue_link_delay (
  input  logic                         clk,
  input  logic                         rst_n,
  pqld_in_if.sink                      in_pkt,
  pqld_out_if.source                   out_res,
  input  logic                         cfg_we,
  input  logic [pqld_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [pqld_pkg::CfgW-1:0]    cfg_data
);
  import pqld_pkg::*;

  pqld_cfg_t  cfg_r;
  pqld_ctrl_t ctrl;

  logic              advance;
  logic              s0_valid_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic [TimeW-1:0]  now0_r;
  logic [BytesW-1:0] bytes0_r;
  logic [TimeW-1:0]  now1_r;
  logic [31:0]       txt1_r;
  logic [47:0]       txt_prod;
  logic [TimeW-1:0]  last_delivery_r;

  logic [32:0]       path_delay;
  logic [TimeW-1:0]  backlog;
  logic              hold;
  logic [TimeW:0]    hold_sum;
  logic [TimeW-1:0]  hold_delivery;
  logic [TimeW:0]    hold_delay;
  logic [TimeW:0]    pass_sum;
  logic [TimeW-1:0]  pass_delivery;
  logic [DelayW-1:0] deliver_nxt;
  logic [QueueW-1:0] queue_nxt;
  logic              mark_nxt;

  logic [DelayW-1:0] deliver_r;
  logic [DelayW-1:0] release_r;
  logic              mark_r;
  logic [QueueW-1:0] queue_r;

  assign advance      = !out_valid_r || out_res.ready;
  assign in_pkt.ready = advance;

  assign ctrl.accept   = in_pkt.valid && advance;
  assign ctrl.advance  = advance;
  assign ctrl.s0_valid = s0_valid_r;
  assign ctrl.s1_valid = s1_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pq_enable      <= 1'b0;
      cfg_r.avoid_reorder  <= 1'b0;
      cfg_r.byte_time      <= ByteTimeReset;
      cfg_r.link_delay     <= '0;
      cfg_r.drain_rate     <= '0;
      cfg_r.mark_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PQ_ENABLE:      cfg_r.pq_enable      <= cfg_data[0];
        REG_AVOID_REORDER:  cfg_r.avoid_reorder  <= cfg_data[0];
        REG_BYTE_TIME:      cfg_r.byte_time      <= cfg_data;
        REG_LINK_DELAY:     cfg_r.link_delay     <= cfg_data;
        REG_DRAIN_RATE:     cfg_r.drain_rate     <= cfg_data;
        REG_MARK_THRESHOLD: cfg_r.mark_threshold <= cfg_data[QueueW-1:0];
        default: begin
        end
      endcase
    end
  end

  pqld_phantom u_phantom (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .cfg          (cfg_r),
    .arrival_time (in_pkt.arrival_time),
    .packet_bytes (in_pkt.packet_bytes),
    .queue_bytes  (queue_nxt),
    .mark_ce      (mark_nxt)
  );

  assign txt_prod = 48'(bytes0_r) * 48'(cfg_r.byte_time);

  always_comb begin
    path_delay = 33'(txt1_r) + 33'(cfg_r.link_delay);
    backlog    = last_delivery_r - now1_r;
    hold       = cfg_r.avoid_reorder && (last_delivery_r > now1_r) &&
                 (48'(path_delay) < backlog);
    // held words queue behind the previous delivery, saturating at the time ceiling
    hold_sum      = (TimeW+1)'(last_delivery_r) + (TimeW+1)'(txt1_r);
    hold_delivery = hold_sum[TimeW] ? TimeMax : hold_sum[TimeW-1:0];
    hold_delay    = hold_sum[TimeW] ? (TimeW+1)'(TimeMax - now1_r)
                                    : (TimeW+1)'(backlog) + (TimeW+1)'(txt1_r);
    pass_sum      = (TimeW+1)'(now1_r) + (TimeW+1)'(path_delay);
    pass_delivery = pass_sum[TimeW] ? TimeMax : pass_sum[TimeW-1:0];
    if (hold) begin
      deliver_nxt = (|hold_delay[TimeW:DelayW]) ? DelayMax : hold_delay[DelayW-1:0];
    end else begin
      deliver_nxt = DelayW'(path_delay);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r      <= 1'b0;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      last_delivery_r <= '0;
    end else if (advance) begin
      s0_valid_r  <= ctrl.accept;
      s1_valid_r  <= s0_valid_r;
      out_valid_r <= s1_valid_r;
      if (s1_valid_r && cfg_r.avoid_reorder) begin
        last_delivery_r <= hold ? hold_delivery : pass_delivery;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      now0_r    <= in_pkt.arrival_time;
      bytes0_r  <= in_pkt.packet_bytes;
      now1_r    <= now0_r;
      txt1_r    <= txt_prod[47:16];
      deliver_r <= deliver_nxt;
      release_r <= DelayW'(txt1_r);
      mark_r    <= mark_nxt;
      queue_r   <= queue_nxt;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.deliver_delay = deliver_r;
  assign out_res.release_delay = release_r;
  assign out_res.mark_ce       = mark_r;
  assign out_res.queue_bytes   = queue_r;

endmodule

[rtl/pqld_phantom.sv]
// phantom queue: elapsed time, drain products and occupancy update
`timescale 1ns / 1ps
module pqld_phantom (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pqld_pkg::pqld_ctrl_t        ctrl,
  input  pqld_pkg::pqld_cfg_t         cfg,
  input  logic [pqld_pkg::TimeW-1:0]  arrival_time,
  input  logic [pqld_pkg::BytesW-1:0] packet_bytes,
  output logic [pqld_pkg::QueueW-1:0] queue_bytes,
  output logic                        mark_ce
);
  import pqld_pkg::*;

  logic [TimeW-1:0]  last_arrival_r;
  logic [TimeW-1:0]  elapsed_r;
  logic [TimeW-1:0]  elapsed_nxt;
  logic [BytesW-1:0] bytes0_r;
  logic [BytesW-1:0] bytes1_r;
  logic [55:0]       hi_prod_r;
  logic [55:0]       hi_prod_nxt;
  logic [55:0]       lo_prod;
  logic [31:0]       lo_part_r;
  logic [QueueW-1:0] phantom_r;
  logic [QueueW-1:0] phantom_nxt;
  logic [56:0]       drained;
  logic [QueueW-1:0] drained_base;
  logic [QueueW:0]   grown;

  // an arrival earlier than the last one counts as no elapsed time
  assign elapsed_nxt = (arrival_time >= last_arrival_r) ? arrival_time - last_arrival_r
                                                        : '0;

  assign hi_prod_nxt = 56'(elapsed_r[47:24]) * 56'(cfg.drain_rate);
  assign lo_prod     = 56'(elapsed_r[23:0]) * 56'(cfg.drain_rate);

  always_comb begin
    drained = {1'b0, hi_prod_r} + 57'(lo_part_r);
    if (drained >= 57'(phantom_r)) begin
      drained_base = '0;
    end else begin
      drained_base = phantom_r - drained[QueueW-1:0];
    end
    grown       = {1'b0, drained_base} + (QueueW+1)'(bytes1_r);
    phantom_nxt = grown[QueueW] ? QueueMax : grown[QueueW-1:0];
  end

  assign queue_bytes = cfg.pq_enable ? phantom_nxt : '0;
  assign mark_ce     = cfg.pq_enable && (phantom_nxt > cfg.mark_threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_arrival_r <= '0;
      phantom_r      <= '0;
    end else begin
      if (ctrl.accept && cfg.pq_enable) begin
        last_arrival_r <= arrival_time;
      end
      if (ctrl.advance && ctrl.s1_valid && cfg.pq_enable) begin
        phantom_r <= phantom_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      elapsed_r <= elapsed_nxt;
      bytes0_r  <= packet_bytes;
      hi_prod_r <= hi_prod_nxt;
      lo_part_r <= lo_prod[55:24];
      bytes1_r  <= bytes0_r;
    end
  end

endmodule

[rtl/pqld_checker.sv]
// port-level checks for the phantom queue link delay block, bound to the top level
`timescale 1ns / 1ps
module pqld_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pqld_pkg::DelayW-1:0] release_delay,
  input logic                        mark_ce,
  input logic [pqld_pkg::QueueW-1:0] queue_bytes
);
  import pqld_pkg::*;

  // a stalled result word stays on the port
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // no result word right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid after reset");

  // an empty output stage always takes a new word
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // transmit time fits in 32 bits
  a_release_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> release_delay[DelayW-1:32] == '0)
    else $error("release delay out of range");

  // a marked word has a non-empty phantom queue
  a_mark_queue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mark_ce |-> queue_bytes != '0)
    else $error("mark with empty phantom queue");

endmodule

bind phantom_queue_link_delay pqld_checker u_pqld_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_pkt.ready),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .release_delay (out_res.release_delay),
  .mark_ce       (out_res.mark_ce),
  .queue_bytes   (out_res.queue_bytes)
);
